// ===== rtl/c2s_pkg.sv =====
// shared widths, angle constants, arctangent table and gain function for the converter
`default_nettype none

package c2s_pkg;

  localparam int DEF_STAGES      = 16;
  localparam int DEF_COORD_BITS  = 24;
  localparam int TABLE_LEN       = 24;
  localparam int SCALED_BITS     = 36;
  localparam int XW              = 40;
  localparam int AW              = 34;
  localparam int KW              = 27;
  localparam int QK              = 26;
  localparam int PW              = XW + KW - 1;
  localparam int ANG_OUT_BITS    = 16;
  localparam logic signed [AW-1:0] ANG_PI   = 34'sd2147483648;
  localparam logic signed [AW-1:0] ANG_HALF = 34'sd32768;
  localparam logic [ANG_OUT_BITS-1:0] INCL_PI = 16'd32768;

  // atan(2^-i) in units of pi / 2^31, truncated
  function automatic logic signed [AW-1:0] atan_unit(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933405;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10680862;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335086;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41721;
      15: r = 34'sd20860;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2607;
      19: r = 34'sd1303;
      20: r = 34'sd651;
      21: r = 34'sd325;
      22: r = 34'sd162;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // gain compensation factor in Q26, evaluated at elaboration
  function automatic logic [63:0] gain_q26(input int stages);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] q;
    int          i;
    p = 64'd1 << 60;
    for (i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    // integer square root, two bits a step
    v     = p;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bit_v > v) begin
        bit_v = bit_v >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (v >= res + bit_v) begin
          v   = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    // rounded reciprocal by long division
    n   = (64'd1 << 56) + (res >> 1);
    rem = '0;
    q   = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (res != 64'd0 && rem >= res) begin
        rem  = rem - res;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/c2s_cell.sv =====
// one cordic vectoring iteration with its pipeline register
`default_nettype none

module c2s_cell import c2s_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic [SW-1:0]        side_i,
  output logic                      v_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [AW-1:0]      a_o,
  output logic [SW-1:0]             side_o
);

  localparam logic signed [AW-1:0] ATAN = atan_unit(IDX);

  logic                 v_r;
  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [AW-1:0] a_r, a_nxt;
  logic [SW-1:0]        side_r;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    // rotate toward the positive x axis
    if (!y_i[XW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      a_nxt = a_i + ATAN;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      a_nxt = a_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign a_o    = a_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// ===== rtl/c2s_gain.sv =====
// two-stage gain compensation multiply with rounding constant
`default_nettype none

module c2s_gain import c2s_pkg::*; #(
  parameter int            SW   = 1,
  parameter int            RS   = QK,
  parameter logic [KW-1:0] GAIN = '0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_i,
  input  wire logic [XW-1:0] x_i,
  input  wire logic [SW-1:0] side_i,
  output logic               v_o,
  output logic [PW-1:0]      sum_o,
  output logic [SW-1:0]      side_o
);

  localparam int            LW  = XW / 2;
  localparam int            HW  = XW - LW;
  localparam logic [PW-1:0] RND = PW'(1) << (RS - 1);

  logic                v0_r, v1_r;
  logic [LW+KW-1:0]    lo_r, lo_nxt;
  logic [HW-1:0]       hi_r;
  logic [SW-1:0]       side0_r, side1_r;
  logic [HW+KW-1:0]    hp;
  logic [PW-1:0]       sum_r, sum_nxt;

  // low half product registered first, with the high half of x; high half product and sum from those registers
  assign lo_nxt  = {{KW{1'b0}}, x_i[LW-1:0]} * {{LW{1'b0}}, GAIN};
  assign hp      = {{KW{1'b0}}, hi_r} * {{HW{1'b0}}, GAIN};
  assign sum_nxt = PW'({hp, {LW{1'b0}}}) + PW'(lo_r) + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= v_i;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r    <= lo_nxt;
      hi_r    <= x_i[XW-1:LW];
      side0_r <= side_i;
      sum_r   <= sum_nxt;
      side1_r <= side0_r;
    end
  end

  assign v_o    = v1_r;
  assign sum_o  = sum_r;
  assign side_o = side1_r;

endmodule

`default_nettype wire

// ===== rtl/cartesian_to_spherical_cordic.sv =====
// cartesian to spherical converter: two chained cordic vectoring rows with gain compensation
//
//  channel | handshake            | beat contents
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | in_x_coord, in_y_coord, in_z_coord
//  out     | out_valid / out_stall| out_radius, out_inclination, out_azimuth,
//          |                      | out_at_origin
//
// one beat enters per cycle while in_stall is low; a beat passes an entry register, a row of
// cordic cells and a gain multiplier for each pass, then the output register.
// synchronous active-low reset clears all valid bits; the pipeline is empty afterwards.
// the whole pipeline holds only when its last stage carries a beat and the output
// register is full and stalled; bubbles keep moving, so input is taken while a
// finished result waits.
`default_nettype none

module cartesian_to_spherical_cordic import c2s_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_STAGES,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_x_coord,
  input  wire logic signed [COORD_BITS-1:0] in_y_coord,
  input  wire logic signed [COORD_BITS-1:0] in_z_coord,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [COORD_BITS-1:0]             out_radius,
  output logic [ANG_OUT_BITS-1:0]           out_inclination,
  output logic signed [ANG_OUT_BITS-1:0]    out_azimuth,
  output logic                              out_at_origin
);

  localparam int CB     = COORD_BITS;
  localparam int GUARD  = SCALED_BITS - CB;
  localparam int NS     = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam logic [63:0]   GAIN_FULL = gain_q26(NS);
  localparam logic [KW-1:0] GAIN_K    = GAIN_FULL[KW-1:0];
  localparam int RS2    = QK + GUARD;
  localparam int SW1    = CB + 2;
  localparam int SW2    = AW + SW1;
  localparam int SWG2   = AW + SW2;

  // side word: {z, xy_zero, z_zero}, angles prepended as the beat moves on
  logic adv, out_load, v_last;

  // pass one entry
  logic                 p1_v_r;
  logic signed [XW-1:0] p1_x_r, p1_x_nxt, p1_y_r, p1_y_nxt;
  logic signed [AW-1:0] p1_a_r, p1_a_nxt;
  logic [SW1-1:0]       p1_side_r, p1_side_nxt;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = XW'($signed({in_x_coord, {GUARD{1'b0}}}));
    ys = XW'($signed({in_y_coord, {GUARD{1'b0}}}));
    // left half plane: reflect and start from plus or minus pi
    if (xs[XW-1]) begin
      p1_x_nxt = -xs;
      p1_y_nxt = -ys;
      p1_a_nxt = ys[XW-1] ? -ANG_PI : ANG_PI;
    end else begin
      p1_x_nxt = xs;
      p1_y_nxt = ys;
      p1_a_nxt = '0;
    end
    p1_side_nxt = {in_z_coord, (in_x_coord == '0) && (in_y_coord == '0), in_z_coord == '0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_x_r    <= p1_x_nxt;
      p1_y_r    <= p1_y_nxt;
      p1_a_r    <= p1_a_nxt;
      p1_side_r <= p1_side_nxt;
    end
  end

  // first row: (x, y) to r_xy and azimuth
  logic                 c1_v [0:NS];
  logic signed [XW-1:0] c1_x [0:NS];
  logic signed [XW-1:0] c1_y [0:NS];
  logic signed [AW-1:0] c1_a [0:NS];
  logic [SW1-1:0]       c1_s [0:NS];

  assign c1_v[0] = p1_v_r;
  assign c1_x[0] = p1_x_r;
  assign c1_y[0] = p1_y_r;
  assign c1_a[0] = p1_a_r;
  assign c1_s[0] = p1_side_r;

  for (genvar k = 0; k < NS; k++) begin : g_row1
    c2s_cell #(.IDX(k), .SW(SW1)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .v_i    (c1_v[k]),
      .x_i    (c1_x[k]),
      .y_i    (c1_y[k]),
      .a_i    (c1_a[k]),
      .side_i (c1_s[k]),
      .v_o    (c1_v[k+1]),
      .x_o    (c1_x[k+1]),
      .y_o    (c1_y[k+1]),
      .a_o    (c1_a[k+1]),
      .side_o (c1_s[k+1])
    );
  end

  logic          g1_v;
  logic [PW-1:0] g1_sum;
  logic [SW2-1:0] g1_side;

  c2s_gain #(.SW(SW2), .RS(QK), .GAIN(GAIN_K)) u_gain1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .v_i    (c1_v[NS]),
    .x_i    (c1_x[NS]),
    .side_i ({c1_a[NS], c1_s[NS]}),
    .v_o    (g1_v),
    .sum_o  (g1_sum),
    .side_o (g1_side)
  );

  // pass two entry: (z, r_xy)
  logic                 p2_v_r;
  logic signed [XW-1:0] p2_x_r, p2_x_nxt, p2_y_r, p2_y_nxt;
  logic signed [AW-1:0] p2_a_r, p2_a_nxt;
  logic [SW2-1:0]       p2_side_r;
  logic signed [XW-1:0] zs, rxy;
  logic signed [CB-1:0] g1_z;

  always_comb begin
    g1_z = g1_side[SW1-1:2];
    zs   = XW'($signed({g1_z, {GUARD{1'b0}}}));
    rxy  = g1_sum[QK +: XW];
    if (zs[XW-1]) begin
      p2_x_nxt = -zs;
      p2_y_nxt = -rxy;
      p2_a_nxt = rxy[XW-1] ? -ANG_PI : ANG_PI;
    end else begin
      p2_x_nxt = zs;
      p2_y_nxt = rxy;
      p2_a_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= g1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_x_r    <= p2_x_nxt;
      p2_y_r    <= p2_y_nxt;
      p2_a_r    <= p2_a_nxt;
      p2_side_r <= g1_side;
    end
  end

  // second row: (z, r_xy) to rho and inclination
  logic                 c2_v [0:NS];
  logic signed [XW-1:0] c2_x [0:NS];
  logic signed [XW-1:0] c2_y [0:NS];
  logic signed [AW-1:0] c2_a [0:NS];
  logic [SW2-1:0]       c2_s [0:NS];

  assign c2_v[0] = p2_v_r;
  assign c2_x[0] = p2_x_r;
  assign c2_y[0] = p2_y_r;
  assign c2_a[0] = p2_a_r;
  assign c2_s[0] = p2_side_r;

  for (genvar k = 0; k < NS; k++) begin : g_row2
    c2s_cell #(.IDX(k), .SW(SW2)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .v_i    (c2_v[k]),
      .x_i    (c2_x[k]),
      .y_i    (c2_y[k]),
      .a_i    (c2_a[k]),
      .side_i (c2_s[k]),
      .v_o    (c2_v[k+1]),
      .x_o    (c2_x[k+1]),
      .y_o    (c2_y[k+1]),
      .a_o    (c2_a[k+1]),
      .side_o (c2_s[k+1])
    );
  end

  logic           g2_v;
  logic [PW-1:0]  g2_sum;
  logic [SWG2-1:0] g2_side;

  c2s_gain #(.SW(SWG2), .RS(RS2), .GAIN(GAIN_K)) u_gain2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .v_i    (c2_v[NS]),
    .x_i    (c2_x[NS]),
    .side_i ({c2_a[NS], c2_s[NS]}),
    .v_o    (g2_v),
    .sum_o  (g2_sum),
    .side_o (g2_side)
  );

  // result formatting
  logic signed [AW-1:0]           th, phi, th_q, phi_q;
  logic signed [CB-1:0]           z_f;
  logic                           xy_zero, z_zero;
  logic [PW-1:0]                  rad_sh;
  logic [CB-1:0]                  rad_c, z_abs;
  logic [ANG_OUT_BITS-1:0]        incl_c;
  logic [CB-1:0]                  radius_nxt;
  logic [ANG_OUT_BITS-1:0]        incl_nxt;
  logic signed [ANG_OUT_BITS-1:0] azim_nxt;

  always_comb begin
    th      = g2_side[SWG2-1 -: AW];
    phi     = g2_side[SW2-1 -: AW];
    z_f     = g2_side[SW1-1:2];
    xy_zero = g2_side[1];
    z_zero  = g2_side[0];
    rad_sh  = g2_sum >> RS2;
    rad_c   = (|rad_sh[PW-1:CB]) ? {CB{1'b1}} : rad_sh[CB-1:0];
    th_q    = (th + ANG_HALF) >>> ANG_OUT_BITS;
    phi_q   = (phi + ANG_HALF) >>> ANG_OUT_BITS;
    // residue can overshoot past either end of 0..pi
    if (th_q[AW-1]) begin
      incl_c = '0;
    end else if (th_q > AW'(INCL_PI)) begin
      incl_c = INCL_PI;
    end else begin
      incl_c = th_q[ANG_OUT_BITS-1:0];
    end
    z_abs = z_f[CB-1] ? CB'(-z_f) : CB'(z_f);
    // on the z axis the cordic result is bypassed
    if (xy_zero) begin
      radius_nxt = z_abs;
      incl_nxt   = z_f[CB-1] ? INCL_PI : '0;
      azim_nxt   = '0;
    end else begin
      radius_nxt = rad_c;
      incl_nxt   = incl_c;
      azim_nxt   = phi_q[ANG_OUT_BITS-1:0];
    end
  end

  // output register and pipeline advance
  logic                           out_v_r;
  logic [CB-1:0]                  out_rad_r;
  logic [ANG_OUT_BITS-1:0]        out_incl_r;
  logic signed [ANG_OUT_BITS-1:0] out_azim_r;
  logic                           out_org_r;

  assign v_last   = g2_v;
  assign out_load = !out_v_r || !out_stall;
  assign adv      = out_load || !v_last;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rad_r  <= radius_nxt;
      out_incl_r <= incl_nxt;
      out_azim_r <= azim_nxt;
      out_org_r  <= xy_zero && z_zero;
    end
  end

  assign out_valid       = out_v_r;
  assign out_radius      = out_rad_r;
  assign out_inclination = out_incl_r;
  assign out_azimuth     = out_azim_r;
  assign out_at_origin   = out_org_r;

  // input held back only behind a beat blocked at the tail
  a_stall_needs_tail: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_last && out_v_r && out_stall))
    else $error("input stalled without a blocked beat at the pipeline tail");

  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_at_origin) |->
      (out_radius == '0 && out_inclination == '0 && out_azimuth == '0))
    else $error("origin beat carries nonzero results");

  a_incl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inclination <= INCL_PI))
    else $error("inclination beyond pi");

  a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && v_last) |=> out_valid)
    else $error("tail beat lost after output drained");

endmodule

`default_nettype wire

// ===== tb/cartesian_to_spherical_cordic_tb.sv =====
// self-checking testbench for the cartesian to spherical cordic converter
module cartesian_to_spherical_cordic_tb import c2s_pkg::*; ();

  localparam int STAGES     = 16;
  localparam int CW         = 24;
  localparam int GUARD      = SCALED_BITS - CW;
  localparam int STAGES_RUN = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
  localparam longint PI_UNITS = 64'sd2147483648;
  localparam longint unsigned RMAX = (64'd1 << CW) - 1;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int LATENCY   = 2 * STAGES_RUN + 7;
  localparam int LIMIT     = 200000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [CW-1:0]                  radius;
    logic [ANG_OUT_BITS-1:0]        inclination;
    logic signed [ANG_OUT_BITS-1:0] azimuth;
    logic                           at_origin;
  } sph_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    sph_t                 want;
  } conv_case_t;

  typedef enum {PT_FULL, PT_SMALL, PT_EXTREME, PT_SCALED, PT_AXIS} pt_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [CW-1:0] in_x_coord = '0;
  logic signed [CW-1:0] in_y_coord = '0;
  logic signed [CW-1:0] in_z_coord = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [CW-1:0] out_radius;
  logic [ANG_OUT_BITS-1:0] out_inclination;
  logic signed [ANG_OUT_BITS-1:0] out_azimuth;
  logic out_at_origin;

  conv_case_t expected_sph[$];
  conv_case_t head;
  longint unsigned gain_k;
  int  mismatches = 0;
  int  checked = 0;
  int  sent = 0;
  int  cycles = 0;
  int  in_held_cycles = 0;
  int  hold_cycles = 0;
  bit  tx_pauses = 1'b1;
  bit  rx_pauses = 1'b1;

  cartesian_to_spherical_cordic #(
    .CORDIC_STAGES (STAGES),
    .COORD_BITS    (CW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_radius      (out_radius),
    .out_inclination (out_inclination),
    .out_azimuth     (out_azimuth),
    .out_at_origin   (out_at_origin)
  );

  always #5 clk = ~clk;

  // atan(2^-i) in units of pi / 2^31
  function automatic longint atan_step(int i);
    longint t [24];
    t = '{536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
          10680862, 5340245, 2670163, 1335086, 667544, 333772,
          166886, 83443, 41721, 20860, 10430, 5215,
          2607, 1303, 651, 325, 162, 81};
    return t[i];
  endfunction

  function automatic longint unsigned cordic_gain_q26();
    longint unsigned p;
    longint unsigned root;
    longint unsigned trial;
    int i;
    p = 64'd1 << 60;
    for (i = 0; i < STAGES_RUN; i++) p += p >> (2 * i);
    root = 0;
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= p) root = trial;
    end
    return ((64'd1 << 56) + root / 2) / root;
  endfunction

  // rotate the vector onto the positive first axis, accumulating the angle
  function automatic void vector_pass(inout longint vx, inout longint vy,
                                      output longint ang);
    longint dx;
    longint dy;
    int i;
    ang = 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? PI_UNITS : -PI_UNITS;
      vx = -vx;
      vy = -vy;
    end
    for (i = 0; i < STAGES_RUN; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx;
        vy -= dy;
        ang += atan_step(i);
      end else begin
        vx -= dx;
        vy += dy;
        ang -= atan_step(i);
      end
    end
  endfunction

  function automatic sph_t spherical_of(logic signed [CW-1:0] xi, logic signed [CW-1:0] yi,
                                        logic signed [CW-1:0] zi);
    longint x, y, z, ax, ay, phi, bx, by, th, th_o, phi_o;
    longint unsigned mag;
    sph_t r;
    x = xi;
    y = yi;
    z = zi;
    r = '0;
    if (x == 0 && y == 0) begin
      if (z == 0) begin
        r.at_origin = 1'b1;
      end else begin
        mag = (z < 0) ? -z : z;
        r.radius = CW'((mag > RMAX) ? RMAX : mag);
        r.inclination = (z < 0) ? INCL_PI : '0;
      end
      return r;
    end
    ax = x <<< GUARD;
    ay = y <<< GUARD;
    vector_pass(ax, ay, phi);
    ax = longint'((unsigned'(ax) * gain_k + (64'd1 << 25)) >> 26);
    bx = z <<< GUARD;
    by = ax;
    vector_pass(bx, by, th);
    mag = (unsigned'(bx) * gain_k + (64'd1 << (25 + GUARD))) >> (26 + GUARD);
    r.radius = CW'((mag > RMAX) ? RMAX : mag);
    th_o = (th + 32768) >>> 16;
    if (th_o < 0) th_o = 0;
    if (th_o > 32768) th_o = 32768;
    phi_o = (phi + 32768) >>> 16;
    r.inclination = th_o[15:0];
    r.azimuth = phi_o[15:0];
    return r;
  endfunction

  task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                            input logic signed [CW-1:0] pz);
    int gap;
    conv_case_t c;
    gap = tx_pauses ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_x_coord <= px;
    in_y_coord <= py;
    in_z_coord <= pz;
    do @(posedge clk); while (in_stall);
    c.x = px;
    c.y = py;
    c.z = pz;
    c.want = spherical_of(px, py, pz);
    expected_sph.push_back(c);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sph.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(pt_kind_t kind);
    logic signed [CW-1:0] v;
    v = CW'($urandom());
    case (kind)
      PT_SMALL: v = CW'($urandom_range(0, 64) - 32);
      PT_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = -1;
          3: v = 0;
          default: v = 1;
        endcase
      end
      PT_SCALED: v = v >>> $urandom_range(1, CW - 2);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_special_points();
    send_point(0, 0, 0);
    send_point(0, 0, C_MAX);
    send_point(0, 0, C_MIN);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(C_MAX, 0, 0);
    send_point(C_MIN, 0, 0);
    send_point(-1, 0, 0);
    send_point(0, C_MAX, 0);
    send_point(0, C_MIN, 0);
    send_point(-100, -1, 0);
    send_point(-100, 1, 5);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MIN, C_MAX, C_MIN);
    send_point(1, 0, C_MAX);
    send_point(1, 0, C_MIN);
    send_point(0, 1, C_MIN);
    send_point(1, 1, 1);
    send_point(-1, -1, -1);
    send_point(1, -1, 0);
    send_point(C_MIN, 0, C_MAX);
    wait_drained();
  endtask

  task automatic test_random_mix(input int n);
    int r;
    pt_kind_t kind;
    logic signed [CW-1:0] px, py, pz;
    repeat (n) begin
      r = $urandom_range(0, 9);
      kind = (r < 5) ? PT_FULL : (r == 5) ? PT_SMALL : (r == 6) ? PT_EXTREME :
             (r == 7) ? PT_SCALED : PT_AXIS;
      if (kind == PT_AXIS) begin
        px = rand_coord(PT_FULL);
        py = rand_coord(PT_SMALL);
        pz = rand_coord(PT_SCALED);
        case ($urandom_range(0, 3))
          0: begin px = 0; py = 0; end
          1: pz = 0;
          2: py = 0;
          default: begin px = 0; py = 0; pz = 0; end
        endcase
      end else begin
        px = rand_coord(kind);
        py = rand_coord(kind);
        pz = rand_coord(kind);
      end
      send_point(px, py, pz);
    end
    wait_drained();
  endtask

  task automatic test_full_rate(input int n);
    tx_pauses = 1'b0;
    rx_pauses = 1'b0;
    repeat (n) send_point(CW'($urandom()), CW'($urandom()), CW'($urandom()));
    wait_drained();
    tx_pauses = 1'b1;
    rx_pauses = 1'b1;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_output_holdoff(input int n);
    tx_pauses = 1'b0;
    hold_cycles = 300;
    repeat (n) send_point(CW'($urandom()), CW'($urandom()), rand_coord(PT_SCALED));
    wait_drained();
    tx_pauses = 1'b1;
  endtask

  // receiver: a stall of random length before each beat while pauses are enabled, or a long hold when asked
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = rx_pauses ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sph.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected beat: radius %0d incl %0d az %0d origin %0b",
                   out_radius, out_inclination, $signed(out_azimuth), out_at_origin);
      end else begin
        head = expected_sph.pop_front();
        checked++;
        if (out_radius !== head.want.radius || out_inclination !== head.want.inclination ||
            out_azimuth !== head.want.azimuth || out_at_origin !== head.want.at_origin) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch (%0d,%0d,%0d): rad %0d/%0d incl %0d/%0d az %0d/%0d org %0b/%0b",
                     head.x, head.y, head.z, head.want.radius, out_radius,
                     head.want.inclination, out_inclination, $signed(head.want.azimuth),
                     $signed(out_azimuth), head.want.at_origin, out_at_origin);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (in_valid && in_stall) in_held_cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_sph.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    gain_k = cordic_gain_q26();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_special_points();
    test_random_mix(500);
    test_full_rate(70);
    test_output_holdoff(80);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d vectors sent, %0d results checked, %0d mismatches", sent, checked,
             mismatches);
    $display("covered axes, origin, left half plane, extremes, full rate, and %0d held cycles",
             in_held_cycles);
    if (mismatches == 0 && expected_sph.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
